FILE: rtl/mmt_pkg.sv
package mmt_pkg;

  // register indexes of the write port
  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegArgA   = 3'd1;
  localparam logic [2:0] RegArgB   = 3'd2;
  localparam logic [2:0] RegArgC   = 3'd3;
  localparam logic [2:0] RegArgD   = 3'd4;
  localparam logic [2:0] RegArgE   = 3'd5;
  localparam logic [2:0] RegFactor = 3'd6;

  // message kinds
  localparam logic [2:0] KindOff   = 3'd0;
  localparam logic [2:0] KindOn    = 3'd1;
  localparam logic [2:0] KindPoly  = 3'd2;
  localparam logic [2:0] KindCc    = 3'd3;
  localparam logic [2:0] KindProg  = 3'd4;
  localparam logic [2:0] KindPres  = 3'd5;
  localparam logic [2:0] KindBend  = 3'd6;
  localparam logic [2:0] KindOther = 3'd7;

  // transform modes
  localparam logic [5:0] ModeChMap     = 6'd1;
  localparam logic [5:0] ModeChSet     = 6'd2;
  localparam logic [5:0] ModeChAdd     = 6'd3;
  localparam logic [5:0] ModeTranspose = 6'd4;
  localparam logic [5:0] ModeSnap      = 6'd5;
  localparam logic [5:0] ModeDiatonic  = 6'd6;
  localparam logic [5:0] ModeNoteMap   = 6'd7;
  localparam logic [5:0] ModeNoteCc    = 6'd8;
  localparam logic [5:0] ModeCcNote    = 6'd9;
  localparam logic [5:0] ModeNoteProg  = 6'd10;
  localparam logic [5:0] ModeVelSet    = 6'd11;
  localparam logic [5:0] ModeVelAdd    = 6'd12;
  localparam logic [5:0] ModeVelScale  = 6'd13;
  localparam logic [5:0] ModeVelClip   = 6'd14;
  localparam logic [5:0] ModeVelComp   = 6'd15;
  localparam logic [5:0] ModeVelInv    = 6'd16;
  localparam logic [5:0] ModeCcMap     = 6'd17;
  localparam logic [5:0] ModeCcAdd     = 6'd18;
  localparam logic [5:0] ModeCcScale   = 6'd19;
  localparam logic [5:0] ModeCcInv     = 6'd20;
  localparam logic [5:0] ModeCcSet     = 6'd21;
  localparam logic [5:0] ModeCcRescale = 6'd22;
  localparam logic [5:0] ModeProgMap   = 6'd23;
  localparam logic [5:0] ModeProgAdd   = 6'd24;
  localparam logic [5:0] ModeBendAdd   = 6'd25;
  localparam logic [5:0] ModeBendScale = 6'd26;
  localparam logic [5:0] ModeBendSet   = 6'd27;
  localparam logic [5:0] ModeBendInv   = 6'd28;
  localparam logic [5:0] ModePresAdd   = 6'd29;
  localparam logic [5:0] ModePresScale = 6'd30;
  localparam logic [5:0] ModePresSet   = 6'd31;
  localparam logic [5:0] ModePresInv   = 6'd32;

  // divider operand widths
  localparam int DivW = 17;
  localparam int DvsW = 8;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DvsW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StSnap  = 8'b0000_0010,
    StDprep = 8'b0000_0100,
    StDiat  = 8'b0000_1000,
    StMul   = 8'b0001_0000,
    StRmul  = 8'b0010_0000,
    StRdiv  = 8'b0100_0000,
    StFin   = 8'b1000_0000
  } state_e;

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // v / 12 for v below 256, by reciprocal
  function automatic logic [4:0] div12(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd171;
    return p[15:11];
  endfunction

  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [7:0] r;
    r = v - ({3'd0, div12(v)} * 8'd12);
    return r[3:0];
  endfunction

  // position of the k-th set bit of a scale mask
  function automatic logic [3:0] deg_at(input logic [11:0] m, input logic [3:0] k);
    logic [3:0]  res;
    logic [11:0] below;
    res = '0;
    for (int p = 0; p < 12; p++) begin
      below = m & ((12'd1 << p) - 12'd1);
      if (m[p] && (4'($countones(below)) == k)) res = 4'(p);
    end
    return res;
  endfunction

endpackage

FILE: rtl/midi_message_transform_core.sv
// channel   dir  word fields (lowest bit first)
// s_axis    in   tuser: kind[2:0]; tdata: channel[4:0] data1[11:5] data2[25:12]
// m_axis    out  tuser: keep[0] out_kind[3:1];
//                tdata: out_channel[4:0] out_data1[11:5] out_data2[25:12]
// cfg       in   cfg_we_i, cfg_idx_i (register 0..6), cfg_wdata_i (16 bit)
//
// one word at a time: plain modes go from accept to the result load directly,
// scale modes through a multiply step, rescale through multiply and divider,
// snap to scale through the scale search, diatonic transpose through the search
// and the divider; input ready returns in the cycle after the load
// reset clears the control state and the configuration registers to their defaults
// a result meeting a full output register holds the sequencer and the input
module midi_message_transform_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // channel, data1, data2, zero pad
  input  logic [2:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_channel, out_data1, out_data2, zero pad
  output logic [3:0]  m_axis_tuser,   // keep, out_kind
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import mmt_pkg::*;

  // configuration registers
  logic [5:0]         mode_q;
  logic signed [14:0] arg_a_q, arg_b_q, arg_c_q, arg_d_q, arg_e_q;
  logic signed [15:0] factor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      arg_a_q  <= '0;
      arg_b_q  <= '0;
      arg_c_q  <= '0;
      arg_d_q  <= '0;
      arg_e_q  <= '0;
      factor_q <= 16'sd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:   mode_q   <= cfg_wdata_i[5:0];
        RegArgA:   arg_a_q  <= cfg_wdata_i[14:0];
        RegArgB:   arg_b_q  <= cfg_wdata_i[14:0];
        RegArgC:   arg_c_q  <= cfg_wdata_i[14:0];
        RegArgD:   arg_d_q  <= cfg_wdata_i[14:0];
        RegArgE:   arg_e_q  <= cfg_wdata_i[14:0];
        RegFactor: factor_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // argument views
  logic signed [31:0] aas, abs32, acs, ads, aes;
  logic [6:0]         a7, b7;
  logic [11:0]        mask;
  assign aas   = 32'(arg_a_q);
  assign abs32 = 32'(arg_b_q);
  assign acs   = 32'(arg_c_q);
  assign ads   = 32'(arg_d_q);
  assign aes   = 32'(arg_e_q);
  assign a7    = 7'(clamp32(aas, 32'sd0, 32'sd127));
  assign b7    = 7'(clamp32(abs32, 32'sd0, 32'sd127));
  assign mask  = arg_b_q[11:0];

  // root pitch class: arg_a offset by a multiple of 12 to stay positive,
  // then reduced mod 12 by reciprocal multiplication
  logic [15:0] root_x, root_r;
  logic [31:0] root_p;
  always_comb begin
    root_x = 16'(arg_a_q) + 16'd16392;
    root_p = {16'd0, root_x} * 32'd43691;
    root_r = root_x - ({3'd0, root_p[31:19]} * 16'd12);
  end

  // sequencer and item registers
  state_e state_q, state_d;
  logic [2:0]  kind_q;
  logic [4:0]  ch_q;
  logic [6:0]  d1_q, s_q;
  logic [13:0] d2_q;
  logic [3:0]  root_q, sd_q, cnt_q, fr_q;
  logic        drop_q, tneg_q, rneg_q;
  logic signed [4:0]  oct_q;
  logic signed [17:0] fq_q, resc_q;
  logic signed [31:0] num_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mmt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // input decode, normalized per kind
  logic [2:0]  in_kind;
  logic [4:0]  in_ch;
  logic [6:0]  in_d1;
  logic [13:0] in_d2;
  logic        accept, in_note_any, in_cc_hit;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_kind = s_axis_tuser;
  assign in_ch   = s_axis_tdata[4:0];
  assign in_d1   = (in_kind == KindBend) ? 7'd0 : s_axis_tdata[11:5];
  always_comb begin
    if (in_kind <= KindCc) in_d2 = {7'd0, s_axis_tdata[18:12]};
    else if (in_kind == KindProg || in_kind == KindPres) in_d2 = '0;
    else in_d2 = s_axis_tdata[25:12];
  end
  assign in_note_any = in_kind <= KindPoly;
  assign in_cc_hit   = (in_kind == KindCc) && (in_d1 == a7);

  // snap search: one distance a cycle, lower candidate first
  logic [7:0] lo_pc_in, hi_pc_in;
  logic       lo_hit, hi_hit;
  always_comb begin
    lo_pc_in = {1'b0, d1_q} + 8'd12 - {4'd0, sd_q} - {4'd0, root_q};
    hi_pc_in = {1'b0, d1_q} + 8'd12 + {4'd0, sd_q} - {4'd0, root_q};
    lo_hit   = (d1_q >= {3'd0, sd_q}) && mask[mod12(lo_pc_in)];
    hi_hit   = (({1'b0, d1_q} + {4'd0, sd_q}) <= 8'd127) && mask[mod12(hi_pc_in)];
  end

  // diatonic setup: degree index of the snapped note and target step
  logic [7:0]         dp_v;
  logic [4:0]         dp_q12;
  logic [3:0]         dp_pc, dp_idx, dp_cnt;
  logic signed [16:0] dp_tgt;
  logic [DivW-1:0]    dp_mag;
  always_comb begin
    dp_v   = {1'b0, s_q} + 8'd12 - {4'd0, root_q};
    dp_q12 = div12(dp_v);
    dp_pc  = mod12(dp_v);
    dp_idx = 4'($countones(mask & ((12'd1 << dp_pc) - 12'd1)));
    dp_cnt = 4'($countones(mask));
    dp_tgt = 17'(arg_c_q) + $signed({13'd0, dp_idx});
    dp_mag = dp_tgt[16] ? DivW'(-dp_tgt) : DivW'(dp_tgt);
  end

  // Q8.8 product for the scale and compress modes
  logic signed [15:0] mul_op;
  logic signed [31:0] mul_base, mul_prod;
  always_comb begin
    mul_op   = $signed({2'd0, d2_q});
    mul_base = '0;
    case (mode_q)
      ModeVelComp: begin
        mul_op   = $signed({2'd0, d2_q}) - 16'sd64;
        mul_base = 32'sd16384;
      end
      ModeBendScale: begin
        mul_op   = $signed({2'd0, d2_q}) - 16'sd8192;
        mul_base = 32'sd2097152;
      end
      ModePresScale: mul_op = $signed({9'd0, d1_q});
      default: ;
    endcase
    mul_prod = mul_op * factor_q;
  end

  // controller range rescale operands
  logic [6:0]         il0, ih0, ol0, oh0, il, ih, ol, oh, rv, rvd, rden;
  logic signed [16:0] rt1, rt2, rnum;
  logic [15:0]        rmag;
  always_comb begin
    il0 = b7;
    ih0 = 7'(clamp32(acs, 32'sd0, 32'sd127));
    ol0 = 7'(clamp32(ads, 32'sd0, 32'sd127));
    oh0 = 7'(clamp32(aes, 32'sd0, 32'sd127));
    if (il0 > ih0) begin
      il = ih0; ih = il0; ol = oh0; oh = ol0;
    end else begin
      il = il0; ih = ih0; ol = ol0; oh = oh0;
    end
    rv   = (d2_q[6:0] < il) ? il : ((d2_q[6:0] > ih) ? ih : d2_q[6:0]);
    rvd  = rv - il;
    rden = ih - il;
    rt1  = $signed({10'd0, ol}) * $signed({10'd0, rden});
    rt2  = $signed({10'd0, rvd}) * ($signed({10'd0, oh}) - $signed({10'd0, ol}));
    rnum = rt1 + rt2;
    rmag = rnum[16] ? 16'(-rnum) : 16'(rnum);
  end

  // divider requests: diatonic wrap, rescale rounding
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      StDprep: begin
        div_req.start    = 1'b1;
        div_req.dividend = dp_mag;
        div_req.divisor  = {4'd0, dp_cnt};
      end
      StRmul: begin
        div_req.start    = (rden != 7'd0);
        div_req.dividend = {rmag, 1'b0} + {9'd0, rden, 1'b0} - {10'd0, rden};
        div_req.divisor  = {rden, 1'b0};
      end
      default: ;
    endcase
  end

  // result assembly
  logic               note_oo, note_any, note_on, is_cc, chan_ok, cc_hit, nt_hit;
  logic signed [31:0] d1s, d2s, rnd;
  logic signed [21:0] dsum, dres;
  logic [3:0]         dg;
  logic               o_keep;
  logic [2:0]         o_kind;
  logic [4:0]         o_ch;
  logic [6:0]         o_d1, lo_v, hi_v;
  logic [13:0]        o_d2;
  logic [15:0]        ch_sum;
  logic signed [31:0] tr_n;

  always_comb begin
    note_oo  = kind_q <= KindOn;
    note_any = kind_q <= KindPoly;
    note_on  = (kind_q == KindOn) && (d2_q != 14'd0);
    is_cc    = kind_q == KindCc;
    chan_ok  = (kind_q != KindOther) && (ch_q >= 5'd1) && (ch_q <= 5'd16);
    cc_hit   = is_cc && (d1_q == a7);
    nt_hit   = note_oo && (d1_q == a7);
    d1s      = $signed({25'd0, d1_q});
    d2s      = $signed({18'd0, d2_q});
    rnd      = (num_q >= 0) ? ((num_q + 32'sd128) >>> 8) : -((-num_q + 32'sd128) >>> 8);
    dg       = deg_at(mask, fr_q);
    dsum     = 22'(oct_q) + 22'(fq_q);
    dres     = $signed({18'd0, root_q}) + dsum * 22'sd12 + $signed({18'd0, dg});
    ch_sum   = 16'(arg_a_q) + {11'd0, ch_q} - 16'd1;
    tr_n     = aas + d1s;
    lo_v     = 7'(clamp32(aas, 32'sd1, 32'sd127));
    hi_v     = 7'(clamp32(abs32, 32'sd1, 32'sd127));
    o_keep   = 1'b1;
    o_kind   = kind_q;
    o_ch     = ch_q;
    o_d1     = d1_q;
    o_d2     = d2_q;
    case (mode_q)
      ModeChMap: begin
        if (chan_ok && ch_q == 5'(clamp32(aas, 32'sd1, 32'sd16)))
          o_ch = 5'(clamp32(abs32, 32'sd1, 32'sd16));
      end
      ModeChSet: if (chan_ok) o_ch = 5'(clamp32(aas, 32'sd1, 32'sd16));
      ModeChAdd: if (chan_ok) o_ch = {1'b0, ch_sum[3:0]} + 5'd1;
      ModeTranspose: begin
        if (note_any) begin
          if (tr_n < 0 || tr_n > 32'sd127) o_keep = 1'b0;
          else o_d1 = 7'(tr_n);
        end
      end
      ModeSnap: begin
        if (note_any && mask != 12'd0) begin
          if (drop_q) o_keep = 1'b0;
          else o_d1 = s_q;
        end
      end
      ModeDiatonic: begin
        if (note_any && mask != 12'd0) begin
          if (drop_q || dres < 0 || dres > 22'sd127) o_keep = 1'b0;
          else o_d1 = 7'(dres);
        end
      end
      ModeNoteMap: if (note_any && d1_q == a7) o_d1 = b7;
      ModeNoteCc: begin
        if (nt_hit) begin
          o_d2   = note_on ? d2_q : 14'd0;
          o_kind = KindCc;
          o_d1   = b7;
        end
      end
      ModeCcNote: begin
        if (cc_hit) begin
          o_d1 = b7;
          if (d2_q >= 14'd64) o_kind = KindOn;
          else begin
            o_kind = KindOff;
            o_d2   = '0;
          end
        end
      end
      ModeNoteProg: begin
        if (nt_hit) begin
          if (!note_on) o_keep = 1'b0;
          else begin
            o_kind = KindProg;
            o_d1   = b7;
            o_d2   = '0;
          end
        end
      end
      ModeVelSet:   if (note_on) o_d2 = 14'(lo_v);
      ModeVelAdd:   if (note_on) o_d2 = 14'(clamp32(d2s + aas, 32'sd1, 32'sd127));
      ModeVelScale: if (note_on) o_d2 = 14'(clamp32(rnd, 32'sd1, 32'sd127));
      ModeVelClip: begin
        if (note_on) begin
          if (lo_v < hi_v)
            o_d2 = 14'(clamp32(d2s, $signed({25'd0, lo_v}), $signed({25'd0, hi_v})));
          else
            o_d2 = 14'(clamp32(d2s, $signed({25'd0, hi_v}), $signed({25'd0, lo_v})));
        end
      end
      ModeVelComp:  if (note_on) o_d2 = 14'(clamp32(rnd, 32'sd1, 32'sd127));
      ModeVelInv:   if (note_on) o_d2 = 14'(clamp32(32'sd128 - d2s, 32'sd1, 32'sd127));
      ModeCcMap:    if (cc_hit) o_d1 = b7;
      ModeCcAdd:    if (cc_hit) o_d2 = 14'(clamp32(d2s + abs32, 32'sd0, 32'sd127));
      ModeCcScale:  if (cc_hit) o_d2 = 14'(clamp32(rnd, 32'sd0, 32'sd127));
      ModeCcInv:    if (cc_hit) o_d2 = 14'd127 - d2_q;
      ModeCcSet:    if (cc_hit) o_d2 = {7'd0, b7};
      ModeCcRescale: if (cc_hit) o_d2 = 14'(clamp32(32'(resc_q), 32'sd0, 32'sd127));
      ModeProgMap:  if (kind_q == KindProg && d1_q == a7) o_d1 = b7;
      ModeProgAdd:  if (kind_q == KindProg) o_d1 = 7'(clamp32(d1s + aas, 32'sd0, 32'sd127));
      ModeBendAdd:  if (kind_q == KindBend) o_d2 = 14'(clamp32(d2s + aas, 32'sd0, 32'sd16383));
      ModeBendScale: if (kind_q == KindBend) o_d2 = 14'(clamp32(rnd, 32'sd0, 32'sd16383));
      ModeBendSet:  if (kind_q == KindBend) o_d2 = 14'(clamp32(aas, 32'sd0, 32'sd16383));
      ModeBendInv: begin
        if (kind_q == KindBend) o_d2 = 14'(clamp32(32'sd16384 - d2s, 32'sd0, 32'sd16383));
      end
      ModePresAdd:   if (kind_q == KindPres) o_d1 = 7'(clamp32(d1s + aas, 32'sd0, 32'sd127));
      ModePresScale: if (kind_q == KindPres) o_d1 = 7'(clamp32(rnd, 32'sd0, 32'sd127));
      ModePresSet:   if (kind_q == KindPres) o_d1 = a7;
      ModePresInv:   if (kind_q == KindPres) o_d1 = 7'd127 - d1_q;
      default: ;
    endcase
    if (!o_keep) begin
      o_kind = '0;
      o_ch   = '0;
      o_d1   = '0;
      o_d2   = '0;
    end
  end

  // output register
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic [3:0]  m_user_q;
  logic        out_free, load;
  assign out_free = !m_valid_q || m_axis_tready;
  assign load     = (state_q == StFin) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if ((mode_q == ModeSnap || mode_q == ModeDiatonic) && in_note_any &&
              (mask != 12'd0)) state_d = StSnap;
          else if (mode_q inside {ModeVelScale, ModeVelComp, ModeCcScale,
                                  ModeBendScale, ModePresScale}) state_d = StMul;
          else if (mode_q == ModeCcRescale && in_cc_hit) state_d = StRmul;
          else state_d = StFin;
        end
      end
      StSnap: begin
        if (lo_hit || hi_hit) state_d = (mode_q == ModeDiatonic) ? StDprep : StFin;
        else if (sd_q == 4'd12) state_d = StFin;
      end
      StDprep: state_d = StDiat;
      StDiat:  if (div_rsp.done) state_d = StFin;
      StMul:   state_d = StFin;
      StRmul:  state_d = (rden == 7'd0) ? StFin : StRdiv;
      StRdiv:  if (div_rsp.done) state_d = StFin;
      StFin:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
      drop_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      if (accept) drop_q <= 1'b0;
      else if (state_q == StSnap && !lo_hit && !hi_hit && sd_q == 4'd12) drop_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_kind;
      ch_q   <= in_ch;
      d1_q   <= in_d1;
      d2_q   <= in_d2;
      root_q <= root_r[3:0];
      sd_q   <= '0;
    end
    if (state_q == StSnap) begin
      if (lo_hit) s_q <= d1_q - {3'd0, sd_q};
      else if (hi_hit) s_q <= d1_q + {3'd0, sd_q};
      sd_q <= sd_q + 4'd1;
    end
    if (state_q == StDprep) begin
      oct_q  <= $signed({1'b0, 4'(dp_q12)}) - 5'sd1;
      tneg_q <= dp_tgt[16];
      cnt_q  <= dp_cnt;
    end
    if (state_q == StDiat && div_rsp.done) begin
      // floor division fixup for a negative step target
      if (tneg_q && div_rsp.rem != 8'd0) begin
        fq_q <= -($signed({1'b0, div_rsp.quot}) + 18'sd1);
        fr_q <= cnt_q - div_rsp.rem[3:0];
      end else if (tneg_q) begin
        fq_q <= -$signed({1'b0, div_rsp.quot});
        fr_q <= div_rsp.rem[3:0];
      end else begin
        fq_q <= $signed({1'b0, div_rsp.quot});
        fr_q <= div_rsp.rem[3:0];
      end
    end
    if (state_q == StMul) num_q <= mul_base + mul_prod;
    if (state_q == StRmul) begin
      rneg_q <= rnum[16];
      resc_q <= $signed({11'd0, ol});
    end
    if (state_q == StRdiv && div_rsp.done)
      resc_q <= rneg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    if (load) begin
      m_data_q <= {6'd0, o_d2, o_d1, o_ch};
      m_user_q <= {o_kind, o_keep};
    end
  end

  assign s_axis_tready = state_q == StIdle;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: rtl/mmt_div.sv
module mmt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmt_pkg::div_req_t req_i,
  output mmt_pkg::div_rsp_t rsp_o
);
  import mmt_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [4:0]      cnt_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW:0]   shl;
  logic [DvsW:0]   trial;

  // restoring step, one quotient bit a cycle
  always_comb begin
    shl   = {rem_q, quo_q[DivW-1]};
    trial = shl - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], ~trial[DvsW]};
      rem_q <= trial[DvsW] ? shl[DvsW-1:0] : trial[DvsW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/mmt_checker.sv
module mmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  // one word in flight: input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accept");

  // a dropped word carries all zero fields
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0 && m_axis_tuser[3:1] == 3'd0)
    else $error("dropped word with nonzero fields");

  // a new result only follows a busy stretch
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind midi_message_transform_core mmt_checker u_mmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/midi_message_transform_checker.sv
module midi_message_transform_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import mmt_pkg::*;

  typedef struct packed {
    logic       keep;
    logic [2:0] kind;
    logic [4:0] chan;
    logic [6:0] d1;
    logic [13:0] d2;
  } msg_t;

  logic [5:0] mode_q;
  int         a_q, b_q, c_q, d_q, e_q, fac_q;
  msg_t       msg_fifo[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // half away from zero
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic int floor_div(int num, int den);
    int q;
    q = num / den;
    if (num % den != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic int pc_of(int v);
    return v - 12 * floor_div(v, 12);
  endfunction

  function automatic bit on_scale(int n, int root, logic [11:0] m);
    return m[pc_of(n - root)];
  endfunction

  function automatic int nearest_scale_note(int note, int root, logic [11:0] m);
    if (on_scale(note, root, m)) return note;
    for (int k = 1; k <= 12; k++) begin
      if (note - k >= 0 && on_scale(note - k, root, m)) return note - k;
      if (note + k <= 127 && on_scale(note + k, root, m)) return note + k;
    end
    return -1;
  endfunction

  function automatic int step_in_scale(int note, int root, logic [11:0] m, int steps);
    int degs[12];
    int cnt, s, base, oct, pc, idx, tgt, res;
    cnt = 0;
    for (int p = 0; p < 12; p++) if (m[p]) begin
      degs[cnt] = p;
      cnt++;
    end
    s = nearest_scale_note(note, root, m);
    if (s < 0) return -1;
    base = s - root;
    oct = floor_div(base, 12);
    pc = base - 12 * oct;
    idx = 0;
    while (idx < cnt && degs[idx] != pc) idx++;
    if (idx == cnt) return -1;
    tgt = idx + steps;
    res = root + 12 * (oct + floor_div(tgt, cnt)) + degs[tgt - cnt * floor_div(tgt, cnt)];
    return (res < 0 || res > 127) ? -1 : res;
  endfunction

  function automatic msg_t transform_msg(logic [2:0] kind_in, logic [31:0] data);
    longint kind, ch, d1, d2, a7, b7, il, ih, ol, oh, t, v, mm;
    bit keep, note_any, note_oo, note_on, is_cc, chan_ok;
    int root, n;
    logic [11:0] mask;
    msg_t r;
    kind = kind_in;
    ch = data[4:0];
    d1 = data[11:5];
    d2 = data[25:12];
    keep = 1;
    a7 = clip(a_q, 0, 127);
    b7 = clip(b_q, 0, 127);
    root = pc_of(a_q);
    mask = b_q[11:0];
    if (kind <= KindCc) d2 &= 127;
    if (kind == KindProg || kind == KindPres) d2 = 0;
    if (kind == KindBend) d1 = 0;
    note_oo = kind <= KindOn;
    note_any = kind <= KindPoly;
    note_on = kind == KindOn && d2 != 0;
    is_cc = kind == KindCc;
    chan_ok = kind != KindOther && ch >= 1 && ch <= 16;
    case (mode_q)
      ModeChMap: if (chan_ok && ch == clip(a_q, 1, 16)) ch = clip(b_q, 1, 16);
      ModeChSet: if (chan_ok) ch = clip(a_q, 1, 16);
      ModeChAdd: if (chan_ok) ch = ((ch - 1 + a_q) % 16 + 16) % 16 + 1;
      ModeTranspose: if (note_any) begin
        if (d1 + a_q < 0 || d1 + a_q > 127) keep = 0; else d1 = d1 + a_q;
      end
      ModeSnap: if (note_any && mask != 0) begin
        n = nearest_scale_note(int'(d1), root, mask);
        if (n < 0) keep = 0; else d1 = n;
      end
      ModeDiatonic: if (note_any && mask != 0) begin
        n = step_in_scale(int'(d1), root, mask, c_q);
        if (n < 0) keep = 0; else d1 = n;
      end
      ModeNoteMap: if (note_any && d1 == a7) d1 = b7;
      ModeNoteCc: if (note_oo && d1 == a7) begin
        d2 = note_on ? d2 : 0;
        kind = KindCc;
        d1 = b7;
      end
      ModeCcNote: if (is_cc && d1 == a7) begin
        d1 = b7;
        if (d2 >= 64) kind = KindOn; else begin
          kind = KindOff;
          d2 = 0;
        end
      end
      ModeNoteProg: if (note_oo && d1 == a7) begin
        if (!note_on) keep = 0; else begin
          kind = KindProg;
          d1 = b7;
          d2 = 0;
        end
      end
      ModeVelSet: if (note_on) d2 = clip(a_q, 1, 127);
      ModeVelAdd: if (note_on) d2 = clip(d2 + a_q, 1, 127);
      ModeVelScale: if (note_on) d2 = clip(round_div(d2 * fac_q, 256), 1, 127);
      ModeVelClip: if (note_on) begin
        il = clip(a_q, 1, 127);
        ih = clip(b_q, 1, 127);
        d2 = il < ih ? clip(d2, il, ih) : clip(d2, ih, il);
      end
      ModeVelComp: if (note_on)
        d2 = clip(round_div(64 * 256 + (d2 - 64) * fac_q, 256), 1, 127);
      ModeVelInv: if (note_on) d2 = clip(128 - d2, 1, 127);
      ModeCcMap: if (is_cc && d1 == a7) d1 = b7;
      ModeCcAdd: if (is_cc && d1 == a7) d2 = clip(d2 + b_q, 0, 127);
      ModeCcScale: if (is_cc && d1 == a7) d2 = clip(round_div(d2 * fac_q, 256), 0, 127);
      ModeCcInv: if (is_cc && d1 == a7) d2 = 127 - d2;
      ModeCcSet: if (is_cc && d1 == a7) d2 = b7;
      ModeCcRescale: if (is_cc && d1 == a7) begin
        il = b7;
        ih = clip(c_q, 0, 127);
        ol = clip(d_q, 0, 127);
        oh = clip(e_q, 0, 127);
        if (il > ih) begin
          t = il; il = ih; ih = t;
          t = ol; ol = oh; oh = t;
        end
        v = clip(d2, il, ih);
        mm = (ih == il) ? ol : round_div(ol * (ih - il) + (v - il) * (oh - ol), ih - il);
        d2 = clip(mm, 0, 127);
      end
      ModeProgMap: if (kind == KindProg && d1 == a7) d1 = b7;
      ModeProgAdd: if (kind == KindProg) d1 = clip(d1 + a_q, 0, 127);
      ModeBendAdd: if (kind == KindBend) d2 = clip(d2 + a_q, 0, 16383);
      ModeBendScale: if (kind == KindBend)
        d2 = clip(round_div(8192 * 256 + (d2 - 8192) * fac_q, 256), 0, 16383);
      ModeBendSet: if (kind == KindBend) d2 = clip(a_q, 0, 16383);
      ModeBendInv: if (kind == KindBend) d2 = clip(16384 - d2, 0, 16383);
      ModePresAdd: if (kind == KindPres) d1 = clip(d1 + a_q, 0, 127);
      ModePresScale: if (kind == KindPres) d1 = clip(round_div(d1 * fac_q, 256), 0, 127);
      ModePresSet: if (kind == KindPres) d1 = clip(a_q, 0, 127);
      ModePresInv: if (kind == KindPres) d1 = 127 - d1;
      default: ;
    endcase
    if (!keep) begin
      kind = 0; ch = 0; d1 = 0; d2 = 0;
    end
    r.keep = keep;
    r.kind = kind[2:0];
    r.chan = ch[4:0];
    r.d1 = d1[6:0];
    r.d2 = d2[13:0];
    return r;
  endfunction

  assign pending_o = msg_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    msg_t want, got;
    if (!rst_ni) begin
      mode_q <= '0;
      a_q <= 0; b_q <= 0; c_q <= 0; d_q <= 0; e_q <= 0;
      fac_q <= 256;
      fail_count_o <= 0;
      msg_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMode:   mode_q <= cfg_wdata_i[5:0];
          RegArgA:   a_q <= int'(signed'(cfg_wdata_i[14:0]));
          RegArgB:   b_q <= int'(signed'(cfg_wdata_i[14:0]));
          RegArgC:   c_q <= int'(signed'(cfg_wdata_i[14:0]));
          RegArgD:   d_q <= int'(signed'(cfg_wdata_i[14:0]));
          RegArgE:   e_q <= int'(signed'(cfg_wdata_i[14:0]));
          RegFactor: fac_q <= int'(signed'(cfg_wdata_i));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tuser[3:1], m_axis_tdata[4:0],
               m_axis_tdata[11:5], m_axis_tdata[25:12]};
        if (msg_fifo.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = msg_fifo.pop_front();
          if (got != want) begin
            if (got.keep != want.keep) $error("keep exp %0d got %0d", want.keep, got.keep);
            if (got.kind != want.kind)
              $error("out_kind exp %0d got %0d", want.kind, got.kind);
            if (got.chan != want.chan)
              $error("out_channel exp %0d got %0d", want.chan, got.chan);
            if (got.d1 != want.d1) $error("out_data1 exp %0d got %0d", want.d1, got.d1);
            if (got.d2 != want.d2) $error("out_data2 exp %0d got %0d", want.d2, got.d2);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // config only changes while idle, so the current copy applies
      if (s_axis_tvalid && s_axis_tready)
        msg_fifo.push_back(transform_msg(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

FILE: tb/midi_message_transform_core_tb.sv
module midi_message_transform_core_tb;
  import mmt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // channel, data1, data2
  logic [2:0]  s_axis_tuser = '0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // out_channel, out_data1, out_data2
  logic [3:0]  m_axis_tuser;        // keep, out_kind
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  int          fail_count;
  int          pending;

  // idle percentages of each side, changed per phase
  int send_idle_pct = 25;
  int recv_idle_pct = 60;
  bit recv_hold = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  midi_message_transform_core dut (.*);

  midi_message_transform_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (recv_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one word, held until accepted; gaps placed before the word
  task automatic send_word(logic [2:0] kind, logic [4:0] chan, logic [6:0] d1,
                           logic [13:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'd0, d2, d1, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // long paths can still be busy; let the worst case pass
    repeat (80) @(posedge clk_i);
  endtask

  // a valid word with random content, mostly in range
  task automatic send_rand();
    logic [2:0] k;
    logic [4:0] c;
    logic [13:0] d2;
    k = 3'($urandom_range(7));
    c = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
    d2 = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(127));
    if (k == KindBend) d2 = 14'($urandom);
    if ($urandom_range(7) == 0) d2 = 14'($urandom_range(1) ? 14'h3fff : 14'd0);
    send_word(k, c, 7'($urandom), d2);
  endtask

  function automatic logic [15:0] rand_arg();
    case ($urandom_range(5))
      0: return 16'h4000;           // most negative 15-bit
      1: return 16'h3fff;           // most positive
      2: return 16'($urandom_range(16'h7fff)) ;
      3: return 16'(-$urandom_range(20));
      default: return 16'($urandom_range(140));
    endcase
  endfunction

  task automatic random_setup();
    logic [15:0] f;
    write_reg(RegMode, 16'($urandom_range(40)));
    write_reg(RegArgA, rand_arg());
    write_reg(RegArgB, ($urandom_range(2) == 0) ? 16'($urandom_range(12'hfff)) : rand_arg());
    write_reg(RegArgC, ($urandom_range(1)) ? 16'(int'($urandom_range(20)) - 10) : rand_arg());
    write_reg(RegArgD, rand_arg());
    write_reg(RegArgE, rand_arg());
    case ($urandom_range(4))
      0: f = 16'h8000;
      1: f = 16'h7fff;
      2: f = 16'($urandom);
      default: f = 16'($urandom_range(768));
    endcase
    write_reg(RegFactor, f);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: pass-through extremes, then each mode value from 0 to 33 on one word
    send_word(KindOn, 5'd16, 7'd127, 14'h3fff);
    send_word(KindOff, 5'd0, 7'd0, 14'd0);
    send_word(KindBend, 5'd31, 7'd127, 14'h3fff);
    send_word(KindOther, 5'd1, 7'd64, 14'd8192);
    drain();
    write_reg(RegArgA, 16'd60);
    write_reg(RegArgB, 16'h0ab5);   // major scale mask
    write_reg(RegArgC, 16'h7ffd);   // -3 steps
    write_reg(RegArgD, 16'd127);
    write_reg(RegArgE, 16'd0);
    write_reg(RegFactor, 16'hff80);  // -0.5
    for (int m = 0; m <= 33; m++) begin
      write_reg(RegMode, 16'(m));
      send_word(3'(m % 7), 5'(m % 17), 7'd60, 14'(m * 4));
      drain();
    end
    // note-on with velocity 0 and an out-of-range transpose
    write_reg(RegMode, 16'(ModeNoteProg));
    send_word(KindOn, 5'd3, 7'd60, 14'd0);
    drain();
    write_reg(RegMode, 16'(ModeTranspose));
    send_word(KindOn, 5'd3, 7'd100, 14'd50);
    drain();

    // random part in phases of idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1 ? 60 : 0);
      recv_idle_pct = (ph == 0) ? 60 : (ph == 1 ? 25 : 0);
      for (int blk = 0; blk < 20; blk++) begin
        random_setup();
        if (blk == 3) recv_hold = 1'b1;
        for (int i = 0; i < 20; i++) send_rand();
        // sender pauses until every result is back
        drain();
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // long receiver hold-off, counted here, so the block fills and stalls
  always @(posedge clk_i) begin
    if (recv_hold) begin
      repeat (300) @(posedge clk_i);
      recv_hold = 1'b0;
    end
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
